>>> hdl/cpid_pkg.sv
// ----------------------------------------------------------------------------
// cpid_pkg
// Types, register map, control word layout and microprogram of the
// cascaded PID controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

	localparam int DATA_W    = 16;
	localparam int ERR_W     = DATA_W + 1;
	localparam int DIFF_W    = DATA_W + 2;
	localparam int INT_W     = 32;
	localparam int GAIN_W    = 16;
	localparam int PROD_W    = GAIN_W + INT_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int FRAC_BITS = 8;
	localparam int N_REGS    = 6;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = ADDR_W - 2;
	localparam int PROG_LEN  = 6;
	localparam int PC_W      = $clog2(PROG_LEN);

	localparam logic [IDX_W-1:0] REG_OUTER_KP = 3'd0;
	localparam logic [IDX_W-1:0] REG_OUTER_KI = 3'd1;
	localparam logic [IDX_W-1:0] REG_OUTER_KD = 3'd2;
	localparam logic [IDX_W-1:0] REG_INNER_KP = 3'd3;
	localparam logic [IDX_W-1:0] REG_INNER_KI = 3'd4;
	localparam logic [IDX_W-1:0] REG_INNER_KD = 3'd5;

	localparam logic signed [GAIN_W-1:0] RST_OUTER_KP = -16'sd1792;
	localparam logic signed [GAIN_W-1:0] RST_INNER_KP = 16'sd768;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_ZERO = 16'sd0;

	localparam logic [1:0] MUL_NONE = 2'd0;
	localparam logic [1:0] MUL_P    = 2'd1;
	localparam logic [1:0] MUL_I    = 2'd2;
	localparam logic [1:0] MUL_D    = 2'd3;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	localparam logic JMP_NEXT = 1'b0;
	localparam logic JMP_LOOP = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] outer_target;
		logic signed [DATA_W-1:0] outer_measure;
		logic signed [DATA_W-1:0] inner_measure;
	} tick_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] outer_output;
		logic signed [DATA_W-1:0] inner_output;
	} result_t;

	typedef struct packed {
		logic       err_en;
		logic       upd_en;
		logic [1:0] mul_sel;
		logic [1:0] acc_op;
		logic       out_en;
		logic       jmp;
	} ctrl_t;

	typedef struct packed {
		ctrl_t cw;
		logic  inner;
		logic  busy;
		logic  done;
	} seq_ctl_t;

	function automatic ctrl_t prog_word(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '0;
		case (pc)
			3'd0: begin
				w.err_en = 1'b1;
			end
			3'd1: begin
				w.upd_en  = 1'b1;
				w.mul_sel = MUL_P;
			end
			3'd2: begin
				w.mul_sel = MUL_I;
				w.acc_op  = ACC_LOAD;
			end
			3'd3: begin
				w.mul_sel = MUL_D;
				w.acc_op  = ACC_ADD;
			end
			3'd4: begin
				w.acc_op = ACC_ADD;
			end
			3'd5: begin
				w.out_en = 1'b1;
				w.jmp    = JMP_LOOP;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hdl/cpid_seq.sv
// ----------------------------------------------------------------------------
// cpid_seq
// Step counter over the microprogram; runs it once for the outer loop and
// once for the inner loop, then reports completion.
// ----------------------------------------------------------------------------
module cpid_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               hold,
	output cpid_pkg::seq_ctl_t ctl
);
	import cpid_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            inner_q;
	logic            busy_q;
	ctrl_t           word;
	logic            last_w;
	logic            step;

	assign word   = prog_word(pc_q);
	assign last_w = (word.jmp == JMP_LOOP) && inner_q;
	assign step   = busy_q && !(last_w && hold);

	always_comb begin
		ctl.cw    = step ? word : '0;
		ctl.inner = inner_q;
		ctl.busy  = busy_q;
		ctl.done  = step && last_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			inner_q <= 1'b0;
			busy_q  <= 1'b0;
		end else if (start && !busy_q) begin
			pc_q    <= '0;
			inner_q <= 1'b0;
			busy_q  <= 1'b1;
		end else if (step) begin
			if (word.jmp == JMP_LOOP) begin
				pc_q <= '0;
				if (inner_q) begin
					busy_q <= 1'b0;
				end else begin
					inner_q <= 1'b1;
				end
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

endmodule

>>> hdl/cascaded_pid_controller_top.sv
// ----------------------------------------------------------------------------
// The microprogram runs 6 steps per loop, outer loop then inner loop, on the
// shared MAC; a new tick is taken only once the last is done. Reset clears
// gains to defaults, integrals and previous errors to zero.
// ----------------------------------------------------------------------------
module cascaded_pid_controller_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  cpid_pkg::tick_t               tick,
	output logic                          result_valid,
	input  logic                          result_ready,
	output cpid_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpid_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import cpid_pkg::*;

	localparam logic signed [ACC_W-1:0] RND_HALF =
		{{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam int SH_W = ACC_W - FRAC_BITS;

	seq_ctl_t ctl;
	logic     start;
	logic     hold;

	logic signed [GAIN_W-1:0] okp_q, oki_q, okd_q, ikp_q, iki_q, ikd_q;
	logic [IDX_W-1:0]         widx;

	tick_t                    tick_q;
	result_t                  rsp_q;
	logic                     rsp_valid_q;
	logic                     first_q;
	logic signed [DATA_W-1:0] oo_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [INT_W-1:0]  integ_q [2];
	logic signed [ERR_W-1:0]  prev_q [2];
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [DATA_W-1:0] tgt;
	logic signed [DATA_W-1:0] meas;
	logic signed [ERR_W-1:0]  err_nx;
	logic signed [INT_W:0]    isum;
	logic signed [INT_W-1:0]  integ_sat;
	logic signed [DIFF_W-1:0] diff_nx;
	logic signed [GAIN_W-1:0] gain;
	logic signed [INT_W-1:0]  opnd;
	logic signed [PROD_W-1:0] prod_nx;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [SH_W-1:0]   shv;
	logic signed [DATA_W-1:0] out_sat;

	cpid_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hold   (hold),
		.ctl    (ctl)
	);

	assign tick_ready   = !ctl.busy;
	assign start        = tick_valid && tick_ready;
	assign hold         = rsp_valid_q && !result_ready;
	assign result_valid = rsp_valid_q;
	assign result       = rsp_q;
	assign pready       = 1'b1;
	assign widx         = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			okp_q <= RST_OUTER_KP;
			oki_q <= RST_GAIN_ZERO;
			okd_q <= RST_GAIN_ZERO;
			ikp_q <= RST_INNER_KP;
			iki_q <= RST_GAIN_ZERO;
			ikd_q <= RST_GAIN_ZERO;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				REG_OUTER_KP: okp_q <= pwdata[GAIN_W-1:0];
				REG_OUTER_KI: oki_q <= pwdata[GAIN_W-1:0];
				REG_OUTER_KD: okd_q <= pwdata[GAIN_W-1:0];
				REG_INNER_KP: ikp_q <= pwdata[GAIN_W-1:0];
				REG_INNER_KI: iki_q <= pwdata[GAIN_W-1:0];
				REG_INNER_KD: ikd_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_OUTER_KP: prdata = 32'(okp_q);
			REG_OUTER_KI: prdata = 32'(oki_q);
			REG_OUTER_KD: prdata = 32'(okd_q);
			REG_INNER_KP: prdata = 32'(ikp_q);
			REG_INNER_KI: prdata = 32'(iki_q);
			REG_INNER_KD: prdata = 32'(ikd_q);
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		tgt     = ctl.inner ? oo_q : tick_q.outer_target;
		meas    = ctl.inner ? tick_q.inner_measure : tick_q.outer_measure;
		err_nx  = ERR_W'(tgt) - ERR_W'(meas);
		isum    = (INT_W+1)'(integ_q[ctl.inner]) + (INT_W+1)'(err_q);
		if (isum[INT_W] != isum[INT_W-1]) begin
			integ_sat = isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
			                        : {1'b0, {(INT_W-1){1'b1}}};
		end else begin
			integ_sat = isum[INT_W-1:0];
		end
		diff_nx = first_q ? '0 : DIFF_W'(err_q) - DIFF_W'(prev_q[ctl.inner]);
		case ({ctl.inner, ctl.cw.mul_sel})
			{1'b0, MUL_P}: gain = okp_q;
			{1'b0, MUL_I}: gain = oki_q;
			{1'b0, MUL_D}: gain = okd_q;
			{1'b1, MUL_P}: gain = ikp_q;
			{1'b1, MUL_I}: gain = iki_q;
			{1'b1, MUL_D}: gain = ikd_q;
			default:       gain = '0;
		endcase
		case (ctl.cw.mul_sel)
			MUL_P:   opnd = INT_W'(err_q);
			MUL_I:   opnd = integ_q[ctl.inner];
			MUL_D:   opnd = INT_W'(diff_q);
			default: opnd = '0;
		endcase
		prod_nx = gain * opnd;
		rnd     = acc_q + RND_HALF;
		shv     = rnd[ACC_W-1:FRAC_BITS];
		if ((&shv[SH_W-1:DATA_W-1]) || !(|shv[SH_W-1:DATA_W-1])) begin
			out_sat = shv[DATA_W-1:0];
		end else begin
			out_sat = shv[SH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
			                      : {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tick_q <= tick;
		end
		if (ctl.cw.err_en) begin
			err_q <= err_nx;
		end
		if (ctl.cw.upd_en) begin
			diff_q <= diff_nx;
		end
		if (ctl.cw.mul_sel != MUL_NONE) begin
			prod_q <= prod_nx;
		end
		case (ctl.cw.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default: ;
		endcase
		if (ctl.cw.out_en && !ctl.inner) begin
			oo_q <= out_sat;
		end
		if (ctl.done) begin
			rsp_q.outer_output <= oo_q;
			rsp_q.inner_output <= out_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q[0]  <= '0;
			integ_q[1]  <= '0;
			prev_q[0]   <= '0;
			prev_q[1]   <= '0;
			first_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.cw.upd_en) begin
				integ_q[ctl.inner] <= integ_sat;
				prev_q[ctl.inner]  <= err_q;
			end
			if (ctl.done) begin
				first_q     <= 1'b0;
				rsp_valid_q <= 1'b1;
			end else if (result_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	ap_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready) |=> ctl.busy)
		else $error("sequencer idle after input transfer");

	ap_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |-> (!rsp_valid_q || result_ready))
		else $error("pending result overwritten");

	ap_first_clears_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> $past(ctl.done))
		else $error("first tick flag cleared without completion");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cascaded PID controller testbench
// Drives control ticks and gain writes into the cascaded PID controller with
// random gaps and result back-pressure, predicts both loop outputs per tick
// and compares them field by field against the results in arrival order.
// Covers the first-tick difference term, half-step rounding, output clamping,
// ignored writes to unused register slots and a full-rate integral run.
// ----------------------------------------------------------------------------
module tb;

	import cpid_pkg::*;

	localparam int LIMIT = 2_000_000;
	localparam int WINDUP_TICKS = 44;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {GAINS_SMALL, GAINS_MAX, GAINS_MIN, GAINS_WIDE, GAINS_MIXED} gain_mode_t;

	class cascade_tracker;
		logic signed [GAIN_W-1:0] gain [N_REGS];
		longint integ [2];
		longint prev_err [2];
		bit first_tick;
		result_t pending_outputs [$];
		int unsigned mismatches;

		function new();
			gain[REG_OUTER_KP] = RST_OUTER_KP;
			gain[REG_OUTER_KI] = RST_GAIN_ZERO;
			gain[REG_OUTER_KD] = RST_GAIN_ZERO;
			gain[REG_INNER_KP] = RST_INNER_KP;
			gain[REG_INNER_KI] = RST_GAIN_ZERO;
			gain[REG_INNER_KD] = RST_GAIN_ZERO;
			integ[0] = 0;
			integ[1] = 0;
			prev_err[0] = 0;
			prev_err[1] = 0;
			first_tick = 1'b1;
			mismatches = 0;
		endfunction

		function void write_gain(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
			if (idx < N_REGS)
				gain[idx] = value;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			hi = (longint'(1) << (w - 1)) - 1;
			if (v > hi)
				return hi;
			if (v < -hi - 1)
				return -hi - 1;
			return v;
		endfunction

		function longint pid_stage(longint target, longint measure, int base, int stage);
			longint err;
			longint diff;
			longint acc;
			err = target - measure;
			integ[stage] = clamp(integ[stage] + err, INT_W);
			diff = first_tick ? 0 : err - prev_err[stage];
			prev_err[stage] = err;
			acc = longint'(gain[base]) * err + longint'(gain[base + 1]) * integ[stage]
				+ longint'(gain[base + 2]) * diff;
			return clamp((acc + 128) >>> FRAC_BITS, DATA_W);
		endfunction

		function void note_tick(tick_t t);
			longint oo;
			longint io;
			result_t r;
			oo = pid_stage(longint'(t.outer_target), longint'(t.outer_measure), REG_OUTER_KP, 0);
			io = pid_stage(oo, longint'(t.inner_measure), REG_INNER_KP, 1);
			first_tick = 1'b0;
			r.outer_output = oo[DATA_W-1:0];
			r.inner_output = io[DATA_W-1:0];
			pending_outputs.push_back(r);
		endfunction

		function void check_result(result_t r);
			result_t want;
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected result outer %0d inner %0d", $time,
					r.outer_output, r.inner_output);
				mismatches++;
				return;
			end
			want = pending_outputs.pop_front();
			if (r.outer_output !== want.outer_output) begin
				$display("%0t: outer_output expected %0d got %0d", $time,
					want.outer_output, r.outer_output);
				mismatches++;
			end
			if (r.inner_output !== want.inner_output) begin
				$display("%0t: inner_output expected %0d got %0d", $time,
					want.inner_output, r.inner_output);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_ready;
	tick_t tick = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bit idle_on = 1'b1;
	int unsigned cycles = 0;
	cascade_tracker tracker;

	cascaded_pid_controller_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick         (tick),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_result(result);
		result_ready <= !(idle_on && $urandom_range(0, 99) < 38);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic tick_t make_tick(logic signed [DATA_W-1:0] tgt,
		logic signed [DATA_W-1:0] om, logic signed [DATA_W-1:0] im);
		tick_t t;
		t.outer_target = tgt;
		t.outer_measure = om;
		t.inner_measure = im;
		return t;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value(logic signed [DATA_W-1:0] near);
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3, 4: return 16'($urandom);
			default: return near + 16'($urandom_range(0, 1024)) - 16'd512;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(gain_mode_t mode);
		case (mode)
			GAINS_MAX: return 16'h7FFF;
			GAINS_MIN: return 16'h8000;
			GAINS_WIDE: return 16'($urandom);
			GAINS_SMALL: return 16'($urandom_range(0, 2048)) - 16'd1024;
			default: return pick_gain(gain_mode_t'($urandom_range(0, 3)));
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		t.outer_target = pick_value(16'($urandom));
		t.outer_measure = pick_value(t.outer_target);
		t.inner_measure = pick_value(16'sd0);
		return t;
	endfunction

	task automatic apb_write(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.write_gain(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_gains(gain_mode_t mode);
		int i;
		for (i = 0; i < N_REGS; i++)
			apb_write(IDX_W'(i), pick_gain(mode));
	endtask

	task automatic send_tick(tick_t t);
		if (idle_on)
			while ($urandom_range(0, 99) < 38) begin
				tick_valid <= 1'b0;
				@(posedge clk);
			end
		tick <= t;
		tick_valid <= 1'b1;
		@(posedge clk);
		while (!tick_ready)
			@(posedge clk);
		tracker.note_tick(t);
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int ph;
		int n;
		gain_mode_t plan [6];
		tracker = new();
		plan = '{GAINS_SMALL, GAINS_MAX, GAINS_MIN, GAINS_WIDE, GAINS_MIXED, GAINS_SMALL};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write(REG_OUTER_KD, 16'sd128);
		apb_write(REG_INNER_KD, -16'sd128);
		apb_write(REG_SPARE_LO, 16'($urandom));
		apb_write(REG_SPARE_HI, 16'($urandom));
		send_tick(make_tick(16'sd256, -16'sd256, 16'sd100));
		send_tick(make_tick(16'sh7FFF, 16'sh8000, 16'sh8000));
		send_tick(make_tick(16'sh8000, 16'sh7FFF, 16'sh7FFF));
		send_tick(make_tick(16'sd0, 16'sd0, 16'sd0));
		send_tick(make_tick(16'sd3, 16'sd0, 16'sd1));
		send_tick(make_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		send_tick(make_tick(16'sh8000, 16'sh8000, 16'sh8000));
		send_tick(make_tick(16'sd1, 16'sd0, 16'sd0));
		send_tick(make_tick(16'sd0, 16'sd1, 16'sd0));
		send_tick(make_tick(-16'sd1, 16'sd0, -16'sd1));
		send_tick(make_tick(16'sh5555, 16'shAAAA, 16'sh00FF));
		send_tick(make_tick(16'shAAAA, 16'sh5555, 16'shFF00));
		send_tick(make_tick(16'sd100, 16'sd99, -16'sd5));
		send_tick(make_tick(-16'sd100, -16'sd99, 16'sd5));
		drain();

		for (ph = 0; ph < 6; ph++) begin
			load_gains(plan[ph]);
			for (n = 0; n < 62; n++)
				send_tick(random_tick());
			drain();
		end

		// grow both integrals at full rate
		idle_on = 1'b0;
		apb_write(REG_OUTER_KP, 16'h7FFF);
		apb_write(REG_OUTER_KI, 16'h0001);
		apb_write(REG_OUTER_KD, 16'h0000);
		apb_write(REG_INNER_KP, 16'h0000);
		apb_write(REG_INNER_KI, 16'h0001);
		apb_write(REG_INNER_KD, 16'h0000);
		for (n = 0; n < WINDUP_TICKS; n++)
			send_tick(make_tick(16'sh7FFF, 16'sh8000, 16'sh8000));
		drain();
		idle_on = 1'b1;

		load_gains(GAINS_SMALL);
		for (n = 0; n < 20; n++)
			send_tick(random_tick());
		drain();

		repeat (24) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
hdl/cpid_pkg.sv
hdl/cpid_seq.sv
hdl/cascaded_pid_controller_top.sv
verif/tb.sv
